@@ rtl/bmbd_pkg.sv @@
package bmbd_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // Register widths.
    localparam int WIDTH_W  = 13;
    localparam int HEIGHT_W = 16;
    localparam int FACTOR_W = 9;
    localparam int MODE_W   = 2;
    localparam int POS_W    = 8;
    localparam int INDEX_W  = 4;
    localparam int DATA_W   = 16;

    // Width used to compare column positions against the row length.
    localparam int WCMP_W = (COL_W + 1 > WIDTH_W) ? (COL_W + 1) : WIDTH_W;

    // Largest bin, in pixels or rows.
    localparam int MAX_FACTOR = 256;

    // Register indexes.
    localparam logic [INDEX_W-1:0] REG_MASK_WIDTH  = INDEX_W'(0);
    localparam logic [INDEX_W-1:0] REG_MASK_HEIGHT = INDEX_W'(1);
    localparam logic [INDEX_W-1:0] REG_BIN_FACTOR  = INDEX_W'(2);
    localparam logic [INDEX_W-1:0] REG_REDUCE_MODE = INDEX_W'(3);

    // Reduction modes.
    localparam logic [MODE_W-1:0] MODE_H_OR  = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_H_AND = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_V_OR  = MODE_W'(2);

    // Register reset values.
    localparam logic [WIDTH_W-1:0]  RST_MASK_WIDTH  = WIDTH_W'(4096);
    localparam logic [HEIGHT_W-1:0] RST_MASK_HEIGHT = HEIGHT_W'(1);
    localparam logic [FACTOR_W-1:0] RST_BIN_FACTOR  = FACTOR_W'(1);
    localparam logic [MODE_W-1:0]   RST_REDUCE_MODE = MODE_H_OR;

    typedef struct packed {
        logic [WIDTH_W-1:0]  mask_width;
        logic [HEIGHT_W-1:0] mask_height;
        logic [FACTOR_W-1:0] bin_factor;
        logic [MODE_W-1:0]   reduce_mode;
    } cfg_t;

    typedef struct packed {
        logic reduced_flag;
        logic row_end;
        logic frame_end;
    } result_t;

    // Line store write request.
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic             data;
    } store_wr_t;

endpackage

@@ rtl/binary_mask_bin_downsampler.sv @@
// Binary mask bin downsampler.
// Input channel s_valid/s_ready carries one mask pixel per item in raster
// order, x fastest. The result channel m_valid/m_ready carries one reduced
// pixel with row-end and frame-end marks each time a bin closes. Modes are
// horizontal OR, horizontal AND and vertical OR; in vertical mode a one-bit
// line store keeps the partial OR of each column between rows.
// The configuration channel cfg_valid/cfg_ready writes one register by index
// (mask width, mask height, bin factor, reduce mode); cfg_ready is always
// high. Writes are to be made only while no item is in flight; the block itself does not enforce it.
// Throughput is one pixel per cycle while s_ready is high. The line store is
// read ahead at the next column, so its single read port and registered read
// allow that rate; a same-column write is forwarded.
// A result is registered into the output buffer, or into its skid entry while
// the output stalls, when the pixel that closes its bin is accepted.
// When the receiver stalls, one more result is taken into a skid entry and
// then s_ready drops until the output drains.
// Reset clears the counters, the running reduction and the output buffer and
// loads the register defaults; the line store needs no clearing because every
// entry is written by the first row of a vertical bin before it is read.
module binary_mask_bin_downsampler
    import bmbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]  cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_pixel_flag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_reduced_flag,
    output logic               m_row_end,
    output logic               m_frame_end
);

    cfg_t             cfg_reg;
    logic             accept;
    logic [COL_W-1:0] rd_addr;
    logic             partial;
    store_wr_t        wr;
    logic             res_valid;
    result_t          res;
    result_t          out_data;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mask_width  <= RST_MASK_WIDTH;
            cfg_reg.mask_height <= RST_MASK_HEIGHT;
            cfg_reg.bin_factor  <= RST_BIN_FACTOR;
            cfg_reg.reduce_mode <= RST_REDUCE_MODE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MASK_WIDTH:  cfg_reg.mask_width  <= cfg_data[WIDTH_W-1:0];
                REG_MASK_HEIGHT: cfg_reg.mask_height <= cfg_data[HEIGHT_W-1:0];
                REG_BIN_FACTOR:  cfg_reg.bin_factor  <= cfg_data[FACTOR_W-1:0];
                REG_REDUCE_MODE: cfg_reg.reduce_mode <= cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign accept = s_valid && s_ready;

    bmbd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .accept     (accept),
        .pixel_flag (s_pixel_flag),
        .partial    (partial),
        .rd_addr    (rd_addr),
        .wr         (wr),
        .res_valid  (res_valid),
        .res        (res)
    );

    bmbd_line_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (partial)
    );

    bmbd_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .out_ready (m_ready)
    );

    assign m_reduced_flag = out_data.reduced_flag;
    assign m_row_end      = out_data.row_end;
    assign m_frame_end    = out_data.frame_end;

    // A result is produced only by an accepted item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> accept)
        else $error("result produced without an accepted item");

    // The line store is written only by an accepted item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> accept)
        else $error("line store written without an accepted item");

    // The input stalls only while the output holds a waiting item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with an empty output");

    // The frame end is always also a row end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> m_row_end)
        else $error("frame end without row end");

endmodule

@@ rtl/bmbd_line_store.sv @@
module bmbd_line_store
    import bmbd_pkg::*;
(
    input  logic             aclk,
    input  store_wr_t        wr,
    input  logic [COL_W-1:0] rd_addr,
    output logic             rd_data
);

    logic mem [MAX_WIDTH];
    logic rd_data_reg;
    logic fwd_hit_reg;
    logic fwd_data_reg;

    // Synchronous write and registered read; a write to the entry being read
    // in the same cycle is forwarded so the read sees the new value.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_hit_reg  <= wr.en && (wr.addr == rd_addr);
        fwd_data_reg <= wr.data;
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

@@ rtl/bmbd_core.sv @@
module bmbd_core
    import bmbd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             accept,
    input  logic             pixel_flag,
    input  logic             partial,
    output logic [COL_W-1:0] rd_addr,
    output store_wr_t        wr,
    output logic             res_valid,
    output result_t          res
);

    logic [COL_W-1:0]    col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [POS_W-1:0]    hpos_reg, hpos_next;
    logic [POS_W-1:0]    vpos_reg, vpos_next;
    logic                run_reg, run_next;

    logic [WCMP_W-1:0]   w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [FACTOR_W-1:0] f_eff;
    logic                last_col, last_row;
    logic                vertical, is_and;
    logic                h_close, v_close;
    logic [FACTOR_W-1:0] hpos_inc, vpos_inc;
    logic                h_acc, v_acc;

    // Effective geometry: zero acts as one, oversize values are clamped.
    always_comb begin
        w_eff = WCMP_W'(cfg.mask_width);
        if (cfg.mask_width == '0) begin
            w_eff = WCMP_W'(1);
        end else if (WCMP_W'(cfg.mask_width) > WCMP_W'(MAX_WIDTH)) begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end
        h_eff = (cfg.mask_height == '0) ? HEIGHT_W'(1) : cfg.mask_height;
        f_eff = cfg.bin_factor;
        if (cfg.bin_factor == '0) begin
            f_eff = FACTOR_W'(1);
        end else if (cfg.bin_factor > FACTOR_W'(MAX_FACTOR)) begin
            f_eff = FACTOR_W'(MAX_FACTOR);
        end
    end

    // Edge detection uses "at or beyond" so stale counters close at once.
    always_comb begin
        last_col = (WCMP_W'(col_reg) + WCMP_W'(1)) >= w_eff;
        last_row = ({1'b0, row_reg} + 17'd1) >= {1'b0, h_eff};
        vertical = (cfg.reduce_mode == MODE_V_OR);
        is_and   = (cfg.reduce_mode == MODE_H_AND);
        hpos_inc = FACTOR_W'(hpos_reg) + FACTOR_W'(1);
        vpos_inc = FACTOR_W'(vpos_reg) + FACTOR_W'(1);
        h_close  = (hpos_inc >= f_eff) || last_col;
        v_close  = (vpos_inc >= f_eff) || last_row;
    end

    // Running reductions for both directions.
    always_comb begin
        if (hpos_reg == '0) begin
            h_acc = pixel_flag;
        end else if (is_and) begin
            h_acc = run_reg & pixel_flag;
        end else begin
            h_acc = run_reg | pixel_flag;
        end
        v_acc = pixel_flag | ((vpos_reg != '0) & partial);
    end

    // Next state of the counters and the result of this item.
    always_comb begin
        col_next  = last_col ? '0 : col_reg + COL_W'(1);
        row_next  = row_reg;
        hpos_next = hpos_reg;
        vpos_next = vpos_reg;
        run_next  = run_reg;
        wr.en     = 1'b0;
        wr.addr   = col_reg;
        wr.data   = v_acc;
        res_valid = 1'b0;
        res.row_end      = last_col;
        res.frame_end    = last_col && last_row;
        res.reduced_flag = vertical ? v_acc : h_acc;

        if (vertical) begin
            hpos_next = '0;
            if (last_col) begin
                vpos_next = v_close ? '0 : vpos_reg + POS_W'(1);
            end
            if (accept) begin
                res_valid = v_close;
                wr.en     = !v_close;
            end
        end else begin
            vpos_next = '0;
            if (h_close) begin
                hpos_next = '0;
                run_next  = 1'b0;
            end else begin
                hpos_next = hpos_reg + POS_W'(1);
                run_next  = h_acc;
            end
            res_valid = accept && h_close;
        end

        if (last_col) begin
            if (last_row) begin
                row_next  = '0;
                vpos_next = '0;
            end else begin
                row_next = row_reg + HEIGHT_W'(1);
            end
        end
    end

    // The store is read ahead at the column of the next item.
    assign rd_addr = accept ? col_next : col_reg;

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            hpos_reg <= '0;
            vpos_reg <= '0;
            run_reg  <= 1'b0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            hpos_reg <= hpos_next;
            vpos_reg <= vpos_next;
            run_reg  <= run_next;
        end
    end

endmodule

@@ rtl/bmbd_out_buf.sv @@
module bmbd_out_buf
    import bmbd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    in_ready,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic    main_valid_reg;
    result_t main_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    // The skid entry catches one item that arrives while the output stalls.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (!main_valid_reg || out_ready) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule
